>>> design/aebk_pkg.sv
package aebk_pkg;

	// Default bank size, handed to the top level parameters
	localparam int VOICES_DEF    = 8;
	localparam int OPERATORS_DEF = 2;
	localparam int ENV_TYPES_DEF = 2;

	// Envelope arithmetic
	localparam int LEVEL_TOP     = 65535;
	localparam int INTERP_SHIFT  = 5;
	localparam int PRODUCT_SHIFT = 16;
	localparam int LEVEL_W       = 17;
	localparam int INCR_W        = 18;
	localparam int PH_W          = 3;
	localparam int SAMPLE_W      = 16;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_TRIGGER = 2'd1,
		OP_RELEASE = 2'd2,
		OP_AUDIO   = 2'd3
	} op_t;

	typedef enum logic [PH_W-1:0] {
		PH_ATTACK  = 3'd0,
		PH_DECAY   = 3'd1,
		PH_SUSTAIN = 3'd2,
		PH_RELEASE = 3'd3,
		PH_QUICK   = 3'd4,
		PH_OFF     = 3'd5
	} phase_t;

	// One request
	typedef struct packed {
		op_t                        op;
		logic [2:0]                 voice;
		logic                       operator_index;
		logic                       env_type;
		logic [LEVEL_W-1:0]         attack_rate;
		logic [LEVEL_W-1:0]         decay_rate;
		logic [LEVEL_W-1:0]         sustain_level;
		logic [LEVEL_W-1:0]         release_rate;
		logic signed [SAMPLE_W-1:0] sample_in;
	} aebk_req_t;

	// One result
	typedef struct packed {
		logic [15:0]                env_level;
		phase_t                     phase_now;
		logic                       is_open;
		logic signed [SAMPLE_W-1:0] sample_out;
	} aebk_rsp_t;

	// Per-envelope values held in the data RAM
	typedef struct packed {
		logic [LEVEL_W-1:0]       level;
		logic [LEVEL_W-1:0]       out_val;
		logic [LEVEL_W-1:0]       tgt_val;
		logic signed [INCR_W-1:0] incr;
	} aebk_entry_t;

	// Lookup status handed to the update logic
	typedef struct packed {
		logic   ent_ok;
		phase_t phase_old;
	} aebk_ctl_t;

endpackage

>>> design/adsr_envelope_bank.sv
// A result is registered in the write-back step that follows the data RAM read
// of its accepted request. A new request is taken only after the last one is
// written back (data RAM read, then modify and write back); a waiting result
// holds the next request in the write-back step until the result is taken.
// Reset: asynchronous, active low. A clearing pass over every envelope address
// then writes every envelope off and zero; req_stall is high meanwhile.
module adsr_envelope_bank import aebk_pkg::*; #(
	parameter int VOICES    = VOICES_DEF,
	parameter int OPERATORS = OPERATORS_DEF,
	parameter int ENV_TYPES = ENV_TYPES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  aebk_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output aebk_rsp_t rsp
);

	localparam int NF    = OPERATORS * ENV_TYPES;
	localparam int NENV  = VOICES * NF;
	localparam int AW    = (NENV > 1) ? $clog2(NENV) : 1;
	localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int FW    = (NF > 1) ? $clog2(NF) : 1;
	localparam int ROW_W = PH_W * NF;
	localparam int ENT_W = $bits(aebk_entry_t);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_cnt_q;
	logic          rsp_valid_q;
	aebk_rsp_t     rsp_q;

	aebk_req_t     req_s1;
	logic          ent_ok_s1;
	logic          voice_ok_s1;
	logic [FW-1:0] fidx_s1;
	logic [AW-1:0] eidx_s1;
	logic [VW-1:0] row_s1;

	logic          accept;
	logic          done;
	logic          clearing;
	logic          clr_row_ok;

	logic          voice_ok;
	logic          oper_ok;
	logic          type_ok;
	logic          ent_ok;
	logic          eff_type;
	int            fidx_int;
	int            eidx_int;
	logic [FW-1:0] fidx;
	logic [AW-1:0] eidx;
	logic [VW-1:0] row;

	logic             dmem_we;
	logic [AW-1:0]    dmem_waddr;
	logic [ENT_W-1:0] dmem_wdata;
	logic [ENT_W-1:0] dmem_rdata;
	logic             pmem_we;
	logic [VW-1:0]    pmem_waddr;
	logic [ROW_W-1:0] pmem_wdata;
	logic [ROW_W-1:0] prow_rd;
	logic [ROW_W-1:0] prow_new;
	logic             pmem_upd;
	logic             dmem_upd;

	aebk_ctl_t   ctl;
	aebk_entry_t ent_rd;
	aebk_entry_t ent_new;
	phase_t      phase_new;
	aebk_rsp_t   rsp_new;

	// Handshake
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign done      = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign clearing  = (state_q == ST_CLEAR);
	assign clr_row_ok = (int'(clr_cnt_q) < VOICES);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Envelope address; audio always addresses the amplitude envelope
	always_comb begin
		eff_type = (req.op == OP_AUDIO) ? 1'b0 : req.env_type;
		voice_ok = (int'(req.voice) < VOICES);
		oper_ok  = (int'(req.operator_index) < OPERATORS);
		type_ok  = (int'(eff_type) < ENV_TYPES);
		ent_ok   = voice_ok && oper_ok && type_ok;
		fidx_int = int'(req.operator_index) * ENV_TYPES + int'(eff_type);
		eidx_int = int'(req.voice) * NF + fidx_int;
		fidx     = ent_ok ? FW'(fidx_int) : '0;
		eidx     = ent_ok ? AW'(eidx_int) : '0;
		row      = voice_ok ? VW'(req.voice) : '0;
	end

	// Lookup results into the update logic
	assign ent_rd        = aebk_entry_t'(dmem_rdata);
	assign ctl.ent_ok    = ent_ok_s1;
	assign ctl.phase_old = phase_t'(prow_rd[PH_W*fidx_s1 +: PH_W]);

	aebk_update u_update (
		.req       (req_s1),
		.ctl       (ctl),
		.ent       (ent_rd),
		.ent_new   (ent_new),
		.phase_new (phase_new),
		.rsp       (rsp_new)
	);

	// Phase row write-back: trigger and release set the whole voice
	always_comb begin
		for (int f = 0; f < NF; f++) begin
			if (req_s1.op == OP_TRIGGER || req_s1.op == OP_RELEASE ||
			    f == int'(fidx_s1)) begin
				prow_new[PH_W*f +: PH_W] = phase_new;
			end else begin
				prow_new[PH_W*f +: PH_W] = prow_rd[PH_W*f +: PH_W];
			end
		end
		pmem_upd = ((req_s1.op == OP_TICK) && ent_ok_s1) ||
		           ((req_s1.op == OP_TRIGGER || req_s1.op == OP_RELEASE) && voice_ok_s1);
		dmem_upd = (req_s1.op == OP_TICK || req_s1.op == OP_AUDIO) && ent_ok_s1;
	end

	// RAM write ports: clearing pass or write-back
	always_comb begin
		dmem_we    = clearing || (done && dmem_upd);
		dmem_waddr = clearing ? clr_cnt_q : eidx_s1;
		dmem_wdata = clearing ? '0 : ENT_W'(ent_new);
		pmem_we    = (clearing && clr_row_ok) || (done && pmem_upd);
		pmem_waddr = clearing ? clr_cnt_q[VW-1:0] : row_s1;
		pmem_wdata = clearing ? {NF{PH_OFF}} : prow_new;
	end

	aebk_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NENV)
	) u_dmem (
		.clk   (clk),
		.we    (dmem_we),
		.waddr (dmem_waddr),
		.wdata (dmem_wdata),
		.re    (accept),
		.raddr (eidx),
		.rdata (dmem_rdata)
	);

	aebk_ram #(
		.WIDTH (ROW_W),
		.DEPTH (VOICES)
	) u_pmem (
		.clk   (clk),
		.we    (pmem_we),
		.waddr (pmem_waddr),
		.wdata (pmem_wdata),
		.re    (accept),
		.raddr (row),
		.rdata (prow_rd)
	);

	// Sequencer: clear, accept and read, then modify, write back and report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			req_s1      <= '0;
			ent_ok_s1   <= 1'b0;
			voice_ok_s1 <= 1'b0;
			fidx_s1     <= '0;
			eidx_s1     <= '0;
			row_s1      <= '0;
		end else begin
			// result taken and no new one behind it
			if (rsp_valid_q && !rsp_stall && !done) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(NENV - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						req_s1      <= req;
						ent_ok_s1   <= ent_ok;
						voice_ok_s1 <= voice_ok;
						fidx_s1     <= fidx;
						eidx_s1     <= eidx;
						row_s1      <= row;
						state_q     <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (done) begin
						rsp_q       <= rsp_new;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// One request at a time: an accept is never followed by another at once
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("request accepted while previous one in flight");

	// Data RAM is never written while a read for a new request may be issued
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dmem_we |-> (state_q != ST_IDLE))
		else $error("data RAM write outside clear or write-back");

	// A new result only comes out of the write-back step
	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result raised without write-back");

	// Stored phases are always legal codes once cleared
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && ent_ok_s1) |-> (prow_rd[PH_W*fidx_s1 +: PH_W] <= PH_OFF))
		else $error("illegal phase code read from phase RAM");

endmodule

>>> design/aebk_ram.sv
module aebk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, registered read that holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/aebk_update.sv
module aebk_update import aebk_pkg::*; (
	input  aebk_req_t   req,
	input  aebk_ctl_t   ctl,
	input  aebk_entry_t ent,
	output aebk_entry_t ent_new,
	output phase_t      phase_new,
	output aebk_rsp_t   rsp
);

	localparam int PROD_W = SAMPLE_W + LEVEL_W + 1;
	localparam logic [LEVEL_W-1:0] TOP_L = LEVEL_W'(LEVEL_TOP);

	logic [LEVEL_W-1:0]        sus_sat;
	logic [LEVEL_W-1:0]        lv_new;
	logic [LEVEL_W+1:0]        sum_a;
	logic signed [LEVEL_W+1:0] dif_d;
	logic signed [LEVEL_W+1:0] dif_r;
	phase_t                    tick_phase;
	logic signed [INCR_W-1:0]  diff;
	logic signed [LEVEL_W+1:0] out_sum;
	logic [LEVEL_W-1:0]        out_sat;
	logic signed [PROD_W-1:0]  prod;

	// Envelope step on a tick
	always_comb begin
		sus_sat    = (req.sustain_level > TOP_L) ? TOP_L : req.sustain_level;
		sum_a      = {2'b00, ent.level} + {2'b00, req.attack_rate};
		dif_d      = $signed({2'b00, ent.level}) - $signed({2'b00, req.decay_rate});
		dif_r      = $signed({2'b00, ent.level}) - $signed({2'b00, req.release_rate});
		lv_new     = ent.level;
		tick_phase = ctl.phase_old;
		case (ctl.phase_old)
			PH_ATTACK: begin
				// stays in attack when the sum lands exactly on top
				if (sum_a > {2'b00, TOP_L}) begin
					lv_new     = TOP_L;
					tick_phase = PH_DECAY;
				end else begin
					lv_new = sum_a[LEVEL_W-1:0];
				end
			end
			PH_DECAY: begin
				if (dif_d < $signed({2'b00, sus_sat})) begin
					lv_new     = sus_sat;
					tick_phase = PH_SUSTAIN;
				end else begin
					lv_new = dif_d[LEVEL_W-1:0];
				end
			end
			PH_SUSTAIN: begin
				lv_new = sus_sat;
			end
			PH_RELEASE: begin
				if (dif_r[LEVEL_W+1]) begin
					lv_new     = '0;
					tick_phase = PH_OFF;
				end else begin
					lv_new = dif_r[LEVEL_W-1:0];
				end
			end
			PH_QUICK: begin
				lv_new     = '0;
				tick_phase = PH_ATTACK;
			end
			default: ;
		endcase
		diff = $signed({1'b0, lv_new}) - $signed({1'b0, ent.tgt_val});
	end

	// Sample scaling and output drift on audio
	always_comb begin
		prod    = PROD_W'(req.sample_in) * PROD_W'($signed({1'b0, ent.out_val}));
		out_sum = $signed({2'b00, ent.out_val}) + (LEVEL_W+2)'(ent.incr);
		if (out_sum[LEVEL_W+1]) begin
			out_sat = '0;
		end else if (out_sum > $signed({2'b00, TOP_L})) begin
			out_sat = TOP_L;
		end else begin
			out_sat = out_sum[LEVEL_W-1:0];
		end
	end

	// New entry, new phase and result by op
	always_comb begin
		ent_new       = ent;
		phase_new     = ctl.phase_old;
		rsp.env_level = ent.out_val[15:0];
		rsp.phase_now = ctl.phase_old;
		rsp.is_open   = (ent.level != '0);
		rsp.sample_out = '0;
		case (req.op)
			OP_TICK: begin
				ent_new.level    = lv_new;
				ent_new.out_val  = ent.tgt_val;
				ent_new.tgt_val  = lv_new;
				ent_new.incr     = diff >>> INTERP_SHIFT;
				phase_new        = tick_phase;
				rsp.env_level    = ent.tgt_val[15:0];
				rsp.phase_now    = tick_phase;
				rsp.is_open      = (lv_new != '0);
			end
			OP_TRIGGER: begin
				phase_new     = PH_QUICK;
				rsp.phase_now = PH_QUICK;
			end
			OP_RELEASE: begin
				phase_new     = PH_RELEASE;
				rsp.phase_now = PH_RELEASE;
			end
			OP_AUDIO: begin
				ent_new.out_val = out_sat;
				rsp.env_level   = out_sat[15:0];
				rsp.sample_out  = prod[PRODUCT_SHIFT +: SAMPLE_W];
			end
			default: ;
		endcase
		// envelope outside the bank reads as off
		if (!ctl.ent_ok) begin
			rsp.env_level  = '0;
			rsp.phase_now  = PH_OFF;
			rsp.is_open    = 1'b0;
			rsp.sample_out = '0;
		end
	end

endmodule
